/* sv/zlxc_pkg.sv */
// Shared types, constants and codes for the zero-lag cross-correlation accumulator.
`default_nettype none

package zlxc_pkg;

	localparam int CELLS_DEF       = 4096;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ACC_BITS_DEF    = 48;

	localparam int CELL_W     = 12;
	localparam int SAMP_W     = 16;
	localparam int GRAD_W     = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KERNEL,
		CFG_DECOMP,
		CFG_UPD_SIGMA,
		CFG_UPD_EPS
	} cfg_idx_t;

	localparam logic [1:0] KERNEL_BORN = 2'd0;
	localparam logic [1:0] KERNEL_MIG  = 2'd1;
	localparam logic [1:0] KERNEL_TOMO = 2'd2;

	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_BORN,
		ACC_SPLIT,
		ACC_CLEAR
	} acc_mode_t;

	typedef struct packed {
		logic              vld;
		logic              in_range;
		logic [CELL_W-1:0] cell_id;
	} item_tag_t;

endpackage

`default_nettype wire

/* sv/zlxc_row_mem.sv */
// Synchronous single-write, single-read row memory with registered read data.
`default_nettype none

module zlxc_row_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 144
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/zlxc_grad_upd.sv */
// Two-multiplier saturating update of one gradient's accumulator row.
`default_nettype none

module zlxc_grad_upd import zlxc_pkg::*; #(
	parameter int SB  = SAMPLE_BITS_DEF,
	parameter int ACC = ACC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire acc_mode_t              mode_s1,
	input  wire logic signed [SB-1:0]   ax_s1,
	input  wire logic signed [SB-1:0]   ay_s1,
	input  wire logic signed [SB-1:0]   bx_s1,
	input  wire logic signed [SB-1:0]   by_s1,
	input  wire logic [3*ACC-1:0]       row_rd,
	output logic [3*ACC-1:0]            row_new,
	output logic                        row_we
);

	localparam int PW = 2 * SB;
	localparam int SW = ((ACC > PW) ? ACC : PW) + 1;
	localparam logic signed [ACC-1:0] HI = {1'b0, {(ACC-1){1'b1}}};
	localparam logic signed [ACC-1:0] LO = {1'b1, {(ACC-1){1'b0}}};

	function automatic logic signed [ACC-1:0] sat_add(
		input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b
	);
		logic signed [SW-1:0] s;
		s = a + b;
		if (s > SW'(HI)) begin
			sat_add = HI;
		end else if (s < SW'(LO)) begin
			sat_add = LO;
		end else begin
			sat_add = ACC'(s);
		end
	endfunction

	logic signed [PW-1:0] prod_a, prod_b;
	logic signed [PW-1:0] prod_a_s2, prod_b_s2;
	logic [3*ACC-1:0]     row_s2;
	acc_mode_t            mode_s2, mode_s3;

	logic signed [ACC-1:0] tot_s2, pa_s2, pb_s2;
	logic signed [ACC-1:0] tot_n, pa_n, pb_n;
	logic signed [ACC-1:0] tot_s3, pa_s3, pb_s3;
	logic signed [ACC-1:0] tot_out;

	assign prod_a = ax_s1 * ay_s1;
	assign prod_b = bx_s1 * by_s1;

	always_ff @(posedge clk) begin
		prod_a_s2 <= prod_a;
		prod_b_s2 <= prod_b;
		row_s2    <= row_rd;
		mode_s2   <= mode_s1;
	end

	assign tot_s2 = row_s2[3*ACC-1:2*ACC];
	assign pa_s2  = row_s2[2*ACC-1:ACC];
	assign pb_s2  = row_s2[ACC-1:0];

	always_comb begin
		tot_n = tot_s2;
		pa_n  = pa_s2;
		pb_n  = pb_s2;
		unique case (mode_s2)
			ACC_BORN: begin
				tot_n = sat_add(SW'(tot_s2), SW'(prod_a_s2));
			end
			ACC_SPLIT: begin
				pa_n = sat_add(SW'(pa_s2), SW'(prod_a_s2));
				pb_n = sat_add(SW'(pb_s2), SW'(prod_b_s2));
			end
			ACC_CLEAR: begin
				tot_n = '0;
				pa_n  = '0;
				pb_n  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		tot_s3  <= tot_n;
		pa_s3   <= pa_n;
		pb_s3   <= pb_n;
		mode_s3 <= mode_s2;
	end

	assign tot_out = (mode_s3 == ACC_SPLIT) ? sat_add(SW'(pa_s3), SW'(pb_s3)) : tot_s3;
	assign row_new = {tot_out, pa_s3, pb_s3};
	assign row_we  = (mode_s3 != ACC_HOLD);

endmodule

`default_nettype wire

/* sv/zero_lag_xcorr_accumulator.sv */
// Top level: command decode, config registers, per-cell row memories and update pipeline.
// A request passes the s1, s2 and s3 registers; done and the result are then registered together.
// Only one request is in flight at a time; busy covers memory read, multiply, add, write-back.
// Reset: a clearing pass zeroes every cell with busy high; config writes allowed.
// done is a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module zero_lag_xcorr_accumulator import zlxc_pkg::*; #(
	parameter int CELLS       = CELLS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int ACC_BITS    = ACC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     command,
	input  wire logic [CELL_W-1:0]        cell_index,
	input  wire logic signed [SAMP_W-1:0] adjoint_full,
	input  wire logic signed [SAMP_W-1:0] adjoint_up,
	input  wire logic signed [SAMP_W-1:0] adjoint_down,
	input  wire logic signed [SAMP_W-1:0] forward_full,
	input  wire logic signed [SAMP_W-1:0] forward_up,
	input  wire logic signed [SAMP_W-1:0] forward_down,
	input  wire logic signed [SAMP_W-1:0] deriv_full,
	input  wire logic signed [SAMP_W-1:0] deriv_up,
	input  wire logic signed [SAMP_W-1:0] deriv_down,
	output logic                          done,
	output logic [CELL_W-1:0]             cell_echo,
	output logic signed [GRAD_W-1:0]      sigma_gradient,
	output logic signed [GRAD_W-1:0]      epsilon_gradient
);

	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SB    = SAMPLE_BITS;
	localparam int ROW_W = 3 * ACC_BITS;

	// config
	logic [1:0] kernel_q;
	logic       decomp_q, upd_sig_q, upd_eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q  <= KERNEL_BORN;
			decomp_q  <= 1'b0;
			upd_sig_q <= 1'b1;
			upd_eps_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_KERNEL:    kernel_q  <= cfg_wdata[1:0];
				CFG_DECOMP:    decomp_q  <= cfg_wdata[0];
				CFG_UPD_SIGMA: upd_sig_q <= cfg_wdata[0];
				CFG_UPD_EPS:   upd_eps_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// request decode
	logic      clr_q;
	logic [AW-1:0] clr_addr_q;
	item_tag_t tag_s1, tag_s2, tag_s3;
	logic      accept, in_range, born, tomo;
	acc_mode_t base_mode, mode_sig, mode_eps;

	logic signed [SB-1:0] a_full, a_up, a_down;
	logic signed [SB-1:0] f_full, f_up, f_down;
	logic signed [SB-1:0] d_full, d_up, d_down;

	assign busy     = clr_q | tag_s1.vld | tag_s2.vld | tag_s3.vld;
	assign accept   = start & ~busy;
	assign in_range = (32'(cell_index) < CELLS);

	assign a_full = $signed(SB'($unsigned(adjoint_full)));
	assign a_up   = $signed(SB'($unsigned(adjoint_up)));
	assign a_down = $signed(SB'($unsigned(adjoint_down)));
	assign f_full = $signed(SB'($unsigned(forward_full)));
	assign f_up   = $signed(SB'($unsigned(forward_up)));
	assign f_down = $signed(SB'($unsigned(forward_down)));
	assign d_full = $signed(SB'($unsigned(deriv_full)));
	assign d_up   = $signed(SB'($unsigned(deriv_up)));
	assign d_down = $signed(SB'($unsigned(deriv_down)));

	always_comb begin
		if (!in_range) begin
			base_mode = ACC_HOLD;
		end else if (command == CMD_CLEAR) begin
			base_mode = ACC_CLEAR;
		end else if (kernel_q == KERNEL_BORN || !decomp_q) begin
			base_mode = ACC_BORN;
		end else if (kernel_q == KERNEL_MIG || kernel_q == KERNEL_TOMO) begin
			base_mode = ACC_SPLIT;
		end else begin
			base_mode = ACC_HOLD;
		end
	end

	assign born     = (base_mode == ACC_BORN);
	assign tomo     = (kernel_q == KERNEL_TOMO);
	assign mode_sig = ((base_mode == ACC_BORN || base_mode == ACC_SPLIT) && !upd_sig_q)
			? ACC_HOLD : base_mode;
	assign mode_eps = ((base_mode == ACC_BORN || base_mode == ACC_SPLIT) && !upd_eps_q)
			? ACC_HOLD : base_mode;

	// operands; born uses the a pair only
	logic signed [SB-1:0] ax_s1, bx_s1;
	logic signed [SB-1:0] sig_ay_s1, sig_by_s1, eps_ay_s1, eps_by_s1;
	acc_mode_t            mode_sig_s1, mode_eps_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_s1       <= born ? a_full : a_down;
			bx_s1       <= a_up;
			sig_ay_s1   <= born ? f_full : (tomo ? f_up : f_down);
			sig_by_s1   <= tomo ? f_down : f_up;
			eps_ay_s1   <= born ? d_full : (tomo ? d_up : d_down);
			eps_by_s1   <= tomo ? d_down : d_up;
			mode_sig_s1 <= mode_sig;
			mode_eps_s1 <= mode_eps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1.vld      <= accept;
			tag_s1.in_range <= in_range;
			tag_s1.cell_id  <= cell_index;
			tag_s2          <= tag_s1;
			tag_s3          <= tag_s2;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(CELLS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// memories and update units
	logic [ROW_W-1:0] sig_rd, eps_rd, sig_new, eps_new;
	logic             sig_chg, eps_chg;
	logic             item_wr;
	logic [AW-1:0]    waddr;

	assign item_wr = tag_s3.vld & tag_s3.in_range;
	assign waddr   = clr_q ? clr_addr_q : AW'(tag_s3.cell_id);

	zlxc_row_mem #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (ROW_W)
	) u_sig_mem (
		.clk   (clk),
		.we    (clr_q | (item_wr & sig_chg)),
		.waddr (waddr),
		.wdata (clr_q ? '0 : sig_new),
		.re    (accept),
		.raddr (AW'(cell_index)),
		.rdata (sig_rd)
	);

	zlxc_row_mem #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (ROW_W)
	) u_eps_mem (
		.clk   (clk),
		.we    (clr_q | (item_wr & eps_chg)),
		.waddr (waddr),
		.wdata (clr_q ? '0 : eps_new),
		.re    (accept),
		.raddr (AW'(cell_index)),
		.rdata (eps_rd)
	);

	zlxc_grad_upd #(
		.SB  (SB),
		.ACC (ACC_BITS)
	) u_sig_upd (
		.clk     (clk),
		.mode_s1 (mode_sig_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (sig_ay_s1),
		.bx_s1   (bx_s1),
		.by_s1   (sig_by_s1),
		.row_rd  (sig_rd),
		.row_new (sig_new),
		.row_we  (sig_chg)
	);

	zlxc_grad_upd #(
		.SB  (SB),
		.ACC (ACC_BITS)
	) u_eps_upd (
		.clk     (clk),
		.mode_s1 (mode_eps_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (eps_ay_s1),
		.bx_s1   (bx_s1),
		.by_s1   (eps_by_s1),
		.row_rd  (eps_rd),
		.row_new (eps_new),
		.row_we  (eps_chg)
	);

	// result
	logic signed [ACC_BITS-1:0] sig_tot, eps_tot;
	logic                       done_q;
	logic [CELL_W-1:0]          cell_q;
	logic signed [GRAD_W-1:0]   sig_q, eps_q;

	assign sig_tot = sig_new[ROW_W-1:2*ACC_BITS];
	assign eps_tot = eps_new[ROW_W-1:2*ACC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s3.vld) begin
			cell_q <= tag_s3.cell_id;
			sig_q  <= tag_s3.in_range ? GRAD_W'(sig_tot) : '0;
			eps_q  <= tag_s3.in_range ? GRAD_W'(eps_tot) : '0;
		end
	end

	assign done             = done_q;
	assign cell_echo        = cell_q;
	assign sigma_gradient   = sig_q;
	assign epsilon_gradient = eps_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({tag_s1.vld, tag_s2.vld, tag_s3.vld}) <= 1)
		else $error("more than one request in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result strobe missing four cycles after accept");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!tag_s3.vld && !done))
		else $error("request active during clearing pass");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(tag_s3.in_range) ||
			(sigma_gradient == '0 && epsilon_gradient == '0)))
		else $error("out-of-range cell gave nonzero gradient");

endmodule

`default_nettype wire
